FILE: src/tim_pkg.sv
// Package for the tick interval monitor: sequencer states, register map,
// reset values, op and status codes and the configuration bundle.
// No dependencies.
package tim_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 64;
  localparam int NOM_W  = 40;
  localparam int WGT_W  = 17;
  localparam int TS_W   = 32;
  localparam int DLT_W  = 42;
  localparam int MIS_W  = 16;

  // register index = paddr[4:3]
  localparam logic [1:0] REG_NOMINAL  = 2'd0;
  localparam logic [1:0] REG_WEIGHT   = 2'd1;
  localparam logic [1:0] REG_ADAPTIVE = 2'd2;

  localparam logic [NOM_W-1:0] NOMINAL_RST  = 40'd25600;
  localparam logic [WGT_W-1:0] WEIGHT_RST   = 17'd6554;
  localparam logic             ADAPTIVE_RST = 1'b1;

  localparam logic [1:0] OP_QUERY   = 2'd0;
  localparam logic [1:0] OP_OBSERVE = 2'd1;
  localparam logic [1:0] OP_RESET   = 2'd2;

  localparam logic [1:0] STS_ON_TIME = 2'd0;
  localparam logic [1:0] STS_LATE    = 2'd1;
  localparam logic [1:0] STS_SILENT  = 2'd2;
  localparam logic [1:0] STS_DEAD    = 2'd3;

  // quotient bits 15..0 plus one saturation probe at bit 16
  localparam int DIV_TOP = 16;

  typedef struct packed {
    logic [NOM_W-1:0] nominal;
    logic [WGT_W-1:0] weight;
    logic             adaptive;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL3,
    ST_MUL10,
    ST_DLT,
    ST_C15,
    ST_C3,
    ST_C10,
    ST_DIV,
    ST_DIFF,
    ST_MUL,
    ST_RND,
    ST_UPD,
    ST_DONE
  } state_t;

endpackage

FILE: src/tim_regs.sv
// Configuration register file of the tick interval monitor: APB-style
// write/read port over nominal interval, smoothing weight and mode.
// Depends on tim_pkg.
module tim_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tim_pkg::ADDR_W-1:0]  paddr,
  input  logic [tim_pkg::DATA_W-1:0]  pwdata,
  output logic [tim_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output tim_pkg::cfg_t               cfg
);
  import tim_pkg::*;

  logic [NOM_W-1:0] nominal_r;
  logic [WGT_W-1:0] weight_r;
  logic             adaptive_r;
  logic             wr_en;
  logic [1:0]       idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[4:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nominal_r  <= NOMINAL_RST;
      weight_r   <= WEIGHT_RST;
      adaptive_r <= ADAPTIVE_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_NOMINAL:  nominal_r  <= pwdata[NOM_W-1:0];
        REG_WEIGHT:   weight_r   <= pwdata[WGT_W-1:0];
        REG_ADAPTIVE: adaptive_r <= pwdata[0];
        default: ;  // drop writes beyond the map
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_NOMINAL:  prdata = {{(DATA_W-NOM_W){1'b0}}, nominal_r};
      REG_WEIGHT:   prdata = {{(DATA_W-WGT_W){1'b0}}, weight_r};
      REG_ADAPTIVE: prdata = {{(DATA_W-1){1'b0}}, adaptive_r};
      default:      prdata = '0;
    endcase
  end

  assign cfg.nominal  = nominal_r;
  assign cfg.weight   = weight_r;
  assign cfg.adaptive = adaptive_r;

endmodule

FILE: src/tick_interval_monitor.sv
// Tick interval monitor: one shared add/subtract unit under a sequencer.
// With no tick seen an accepted item goes straight to issue; otherwise the sequencer runs
// scaling, delta and threshold compares, up to 17 restoring-divider steps, the EWMA
// multiply, round and update of an adaptive observe, then the issue state.
// One item at a time: the next beat is taken the cycle after the result issues; out_stall
// delays the issue. Reset (synchronous, rst_n low) restores registers, clears the tracker.
module tick_interval_monitor #(
  parameter int FRAC_BITS   = 8,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_op,
  input  logic [tim_pkg::TS_W-1:0]          in_timestamp,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_status,
  output logic signed [tim_pkg::DLT_W-1:0]  out_delta,
  output logic [tim_pkg::MIS_W-1:0]         out_missed_ticks,
  output logic [tim_pkg::TS_W-1:0]          out_tick_total,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tim_pkg::ADDR_W-1:0]        paddr,
  input  logic [tim_pkg::DATA_W-1:0]        pwdata,
  output logic [tim_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);
  import tim_pkg::*;

  localparam int AW1 = (FRAC_BITS + 35 > 58) ? FRAC_BITS + 35 : 58;
  localparam int AW  = (WEIGHT_BITS + 43 > AW1) ? WEIGHT_BITS + 43 : AW1;
  localparam int CMX = (WEIGHT_BITS > DIV_TOP) ? WEIGHT_BITS : DIV_TOP;
  localparam int CW  = $clog2(CMX + 1);
  localparam int WW  = (WEIGHT_BITS + 1 > WGT_W) ? WEIGHT_BITS + 1 : WGT_W;

  localparam logic signed [AW-1:0] MASK40_A = $signed({{(AW-NOM_W){1'b0}}, {NOM_W{1'b1}}});
  localparam logic signed [AW-1:0] DMAX_A =
    $signed({{(AW-DLT_W+1){1'b0}}, {(DLT_W-1){1'b1}}});
  localparam logic signed [AW-1:0] DMIN_A =
    $signed({{(AW-DLT_W+1){1'b1}}, {(DLT_W-1){1'b0}}});
  localparam logic signed [AW-1:0] HALF_A = $signed(AW'(1) << (WEIGHT_BITS - 1));

  cfg_t cfg;

  tim_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  state_t state_r, state_nxt;

  // tracker state
  logic              seen_r;
  logic [TS_W-1:0]   last_r;
  logic [NOM_W-1:0]  smooth_r;
  logic [TS_W-1:0]   tcnt_r;

  // per-item working registers
  logic [1:0]            op_r;
  logic [TS_W-1:0]       ts_r;
  logic signed [AW-1:0]  el_r;
  logic                  pos_r;
  logic [NOM_W-1:0]      eff_r;
  logic signed [AW-1:0]  e3_r, e10_r, dl_r, rem_r, dv_r, d_r, acc_r;
  logic                  lt15_r, lt3_r, lt10_r;
  logic [MIS_W-1:0]      q_r;
  logic                  sat_r;
  logic [CW-1:0]         cnt_r;
  logic [WEIGHT_BITS:0]  w_r;

  // output register
  logic                  out_valid_r;
  logic [1:0]            status_r;
  logic [DLT_W-1:0]      delta_r;
  logic [MIS_W-1:0]      missed_r;
  logic [TS_W-1:0]       total_r;

  // shared unit
  logic signed [AW-1:0]  ua, ub, usum;
  logic                  usub;
  logic                  nonneg;

  logic                  in_acc, done_fire, div_go, ewma_go;
  logic [TS_W:0]         diff;
  logic signed [AW-1:0]  effa, smootha, obsa;
  logic [WW-1:0]         wext, dext;
  logic [WEIGHT_BITS:0]  wsat;
  logic [1:0]            status_c;
  logic [DLT_W-1:0]      delta_c;
  logic [MIS_W-1:0]      missed_c;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign done_fire = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  assign diff    = {1'b0, in_timestamp} - {1'b0, last_r};
  assign effa    = $signed({{(AW-NOM_W){1'b0}}, eff_r});
  assign smootha = $signed({{(AW-NOM_W){1'b0}}, smooth_r});
  assign obsa    = (el_r > MASK40_A) ? MASK40_A : el_r;

  assign wext = WW'(cfg.weight);
  assign dext = WW'(1) << WEIGHT_BITS;
  assign wsat = (wext > dext) ? dext[WEIGHT_BITS:0] : wext[WEIGHT_BITS:0];

  assign div_go  = seen_r && (eff_r != '0) && pos_r;
  assign ewma_go = (op_r == OP_OBSERVE) && seen_r && cfg.adaptive && pos_r;

  assign usum   = usub ? (ua - ub) : (ua + ub);
  assign nonneg = !usum[AW-1];

  // operand selection for the shared unit
  always_comb begin
    ua   = '0;
    ub   = '0;
    usub = 1'b0;
    unique case (state_r)
      ST_MUL3: begin
        ua = effa;
        ub = effa <<< 1;
      end
      ST_MUL10: begin
        ua = effa <<< 3;
        ub = effa <<< 1;
      end
      ST_DLT: begin
        ua = el_r;  ub = effa;  usub = 1'b1;
      end
      ST_C15: begin
        ua = el_r <<< 1;  ub = e3_r;  usub = 1'b1;
      end
      ST_C3: begin
        ua = el_r;  ub = e3_r;  usub = 1'b1;
      end
      ST_C10: begin
        ua = el_r;  ub = e10_r;  usub = 1'b1;
      end
      ST_DIV: begin
        ua = rem_r;  ub = dv_r;  usub = 1'b1;
      end
      ST_DIFF: begin
        ua = obsa;  ub = smootha;  usub = 1'b1;
      end
      ST_MUL: begin
        ua = acc_r <<< 1;
        ub = w_r[WEIGHT_BITS] ? d_r : '0;
      end
      ST_RND: begin
        ua = acc_r;  ub = HALF_A;
      end
      ST_UPD: begin
        ua = smootha;  ub = acc_r >>> WEIGHT_BITS;
      end
      ST_IDLE, ST_DONE: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = seen_r ? ST_MUL3 : ST_DONE;
      ST_MUL3:  state_nxt = ST_MUL10;
      ST_MUL10: state_nxt = ST_DLT;
      ST_DLT:   state_nxt = ST_C15;
      ST_C15:   state_nxt = ST_C3;
      ST_C3:    state_nxt = ST_C10;
      ST_C10: begin
        if (div_go)       state_nxt = ST_DIV;
        else if (ewma_go) state_nxt = ST_DIFF;
        else              state_nxt = ST_DONE;
      end
      ST_DIV: begin
        if ((cnt_r == CW'(DIV_TOP) && nonneg) || cnt_r == '0) begin
          state_nxt = ewma_go ? ST_DIFF : ST_DONE;
        end
      end
      ST_DIFF:  state_nxt = ST_MUL;
      ST_MUL:   if (cnt_r == '0) state_nxt = ST_RND;
      ST_RND:   state_nxt = ST_UPD;
      ST_UPD:   state_nxt = ST_DONE;
      ST_DONE:  if (done_fire) state_nxt = ST_IDLE;
    endcase
  end

  // result fields from the working registers
  always_comb begin
    if (!seen_r || eff_r == '0) status_c = STS_DEAD;
    else if (lt15_r)            status_c = STS_ON_TIME;
    else if (lt3_r)             status_c = STS_LATE;
    else if (lt10_r)            status_c = STS_SILENT;
    else                        status_c = STS_DEAD;

    if (!seen_r)             delta_c = '0;
    else if (dl_r > DMAX_A)  delta_c = DMAX_A[DLT_W-1:0];
    else if (dl_r < DMIN_A)  delta_c = DMIN_A[DLT_W-1:0];
    else                     delta_c = dl_r[DLT_W-1:0];

    if (sat_r)           missed_c = '1;
    else if (q_r == '0)  missed_c = '0;
    else                 missed_c = q_r - MIS_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_r  <= in_op;
          ts_r  <= in_timestamp;
          el_r  <= $signed({{(AW-TS_W-1-FRAC_BITS){diff[TS_W]}}, diff, {FRAC_BITS{1'b0}}});
          pos_r <= !diff[TS_W] && (diff != '0);
          eff_r <= cfg.adaptive ? smooth_r : cfg.nominal;
          q_r   <= '0;
          sat_r <= 1'b0;
        end
      end
      ST_MUL3:  e3_r   <= usum;
      ST_MUL10: e10_r  <= usum;
      ST_DLT:   dl_r   <= usum;
      ST_C15:   lt15_r <= usum[AW-1];
      ST_C3:    lt3_r  <= usum[AW-1];
      ST_C10: begin
        lt10_r <= usum[AW-1];
        rem_r  <= el_r;
        dv_r   <= effa <<< DIV_TOP;
        cnt_r  <= CW'(DIV_TOP);
      end
      ST_DIV: begin
        // first probe only detects a quotient past the 16-bit range
        if (cnt_r == CW'(DIV_TOP)) begin
          sat_r <= nonneg;
        end else begin
          q_r <= {q_r[MIS_W-2:0], nonneg};
          if (nonneg) rem_r <= usum;
        end
        dv_r  <= dv_r >>> 1;
        cnt_r <= cnt_r - CW'(1);
      end
      ST_DIFF: begin
        d_r   <= usum;
        acc_r <= '0;
        w_r   <= wsat;
        cnt_r <= CW'(WEIGHT_BITS);
      end
      ST_MUL: begin
        acc_r <= usum;
        w_r   <= {w_r[WEIGHT_BITS-1:0], 1'b0};
        cnt_r <= cnt_r - CW'(1);
      end
      ST_RND, ST_UPD: acc_r <= usum;
      ST_DONE: ;
    endcase
  end

  // tracker update once the result beat is issued
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r   <= 1'b0;
      last_r   <= '0;
      smooth_r <= NOMINAL_RST;
      tcnt_r   <= '0;
    end else if (done_fire) begin
      if (op_r == OP_OBSERVE) begin
        if (ewma_go) smooth_r <= acc_r[NOM_W-1:0];
        seen_r <= 1'b1;
        last_r <= ts_r;
        if (tcnt_r != '1) tcnt_r <= tcnt_r + TS_W'(1);
      end else if (op_r == OP_RESET) begin
        seen_r   <= 1'b0;
        last_r   <= '0;
        smooth_r <= cfg.nominal;
        tcnt_r   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      status_r <= status_c;
      delta_r  <= delta_c;
      missed_r <= div_go ? missed_c : '0;
      total_r  <= tcnt_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_delta        = $signed(delta_r);
  assign out_missed_ticks = missed_r;
  assign out_tick_total   = total_r;

endmodule
